/* hdl/gtf_pkg.sv */
// ---------------------------------------------------------------------------
// gtf_pkg
// shared types, codes and default sizes of the grouped team queue
// ---------------------------------------------------------------------------
package gtf_pkg;

  localparam int unsigned DefTeams      = 64;
  localparam int unsigned DefElements   = 1024;
  localparam int unsigned DefQueueDepth = 1024;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned ElemW   = 10;
  localparam int unsigned TeamW   = 7;
  localparam int unsigned StatusW = 2;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_ASSIGN  = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STS_DONE  = 2'd0,
    STS_VALUE = 2'd1,
    STS_EMPTY = 2'd2,
    STS_FULL  = 2'd3
  } status_e;

endpackage

/* hdl/gtf_ram.sv */
// ---------------------------------------------------------------------------
// gtf_ram
// simple dual-port memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module gtf_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 1,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/grouped_team_fifo.sv */
// ---------------------------------------------------------------------------
// grouped_team_fifo
// team queue: assign, enqueue, dequeue and clear over linked lists in ram
// ---------------------------------------------------------------------------
// One request is worked at a time. Assign, an enqueue on a full queue, a
// dequeue on an empty queue and clear answer from idle; a teamless enqueue
// passes ENQ1, an enqueue with a team ENQ1 and ENQ2, a teamless dequeue DEQ1
// and DEQ3, a dequeue from a team DEQ1 to DEQ3, along the chain of dependent
// registered reads through the membership, free list, team, group ring and
// node memories. After reset and after every clear a sweep over max(ELEMENTS,
// QUEUE_DEPTH, TEAMS) addresses zeroes the membership and team memories and
// refills the free list, taking no request. A new request is taken only when
// the output register is empty or its response leaves in that same cycle.
module grouped_team_fifo
  import gtf_pkg::*;
#(
  parameter int unsigned TEAMS       = DefTeams,
  parameter int unsigned ELEMENTS    = DefElements,
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // cmd, element, team
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // value, status
);

  localparam int unsigned EW  = $clog2(ELEMENTS);
  localparam int unsigned NW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned TW  = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned GW  = 1 + ((NW > TW) ? NW : TW);
  localparam int unsigned SD0 = (ELEMENTS > QUEUE_DEPTH) ? ELEMENTS : QUEUE_DEPTH;
  localparam int unsigned SD  = (SD0 > TEAMS) ? SD0 : TEAMS;
  localparam int unsigned SW  = $clog2(SD);
  localparam int unsigned XW  = 1 + 2 * NW;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_ENQ1, ST_ENQ2, ST_DEQ1, ST_DEQ2, ST_DEQ3
  } state_e;

  state_e state_q, state_d;

  logic [CmdW-1:0]  in_cmd;
  logic [ElemW-1:0] in_elem;
  logic [TeamW-1:0] in_team;
  assign in_cmd  = s_axis_tdata[CmdW-1:0];
  assign in_elem = s_axis_tdata[CmdW+ElemW-1:CmdW];
  assign in_team = s_axis_tdata[CmdW+ElemW+TeamW-1:CmdW+ElemW];

  logic [SW-1:0]    sweep_q, sweep_d;
  logic [CW-1:0]    count_q, count_d;
  logic [NW-1:0]    ghead_q, ghead_d, gtail_q, gtail_d;
  logic [ElemW-1:0] elem_q, elem_d;
  logic [NW-1:0]    node_q, node_d;
  logic [TW-1:0]    ti_q, ti_d;
  logic             solo_q, solo_d;
  logic [XW-1:0]    tent_q, tent_d;
  logic             ovalid_q, ovalid_d;
  logic [ElemW-1:0] ovalue_q, ovalue_d;
  logic [StatusW-1:0] ostatus_q, ostatus_d;

  // memory ports
  logic             mo_we;  logic [EW-1:0] mo_wa, mo_ra;
  logic [TeamW-1:0] mo_wd, mo_rd;
  logic             fr_we;  logic [NW-1:0] fr_wa, fr_ra, fr_wd, fr_rd;
  logic             nv_we;  logic [NW-1:0] nv_wa, nv_ra;
  logic [ElemW-1:0] nv_wd, nv_rd;
  logic             nn_we;  logic [NW-1:0] nn_wa, nn_ra, nn_wd, nn_rd;
  logic             tm_we;  logic [TW-1:0] tm_wa, tm_ra;
  logic [XW-1:0]    tm_wd, tm_rd;
  logic             gr_we;  logic [NW-1:0] gr_wa;
  logic [GW-1:0]    gr_wd, gr_rd;

  gtf_ram #(.Depth(ELEMENTS), .Width(TeamW)) u_member (
    .clk_i, .we_i(mo_we), .waddr_i(mo_wa), .wdata_i(mo_wd), .raddr_i(mo_ra), .rdata_o(mo_rd));
  gtf_ram #(.Depth(QUEUE_DEPTH), .Width(NW)) u_free (
    .clk_i, .we_i(fr_we), .waddr_i(fr_wa), .wdata_i(fr_wd), .raddr_i(fr_ra), .rdata_o(fr_rd));
  gtf_ram #(.Depth(QUEUE_DEPTH), .Width(ElemW)) u_nval (
    .clk_i, .we_i(nv_we), .waddr_i(nv_wa), .wdata_i(nv_wd), .raddr_i(nv_ra), .rdata_o(nv_rd));
  gtf_ram #(.Depth(QUEUE_DEPTH), .Width(NW)) u_nnext (
    .clk_i, .we_i(nn_we), .waddr_i(nn_wa), .wdata_i(nn_wd), .raddr_i(nn_ra), .rdata_o(nn_rd));
  gtf_ram #(.Depth(TEAMS), .Width(XW), .AddrW(TW)) u_team (
    .clk_i, .we_i(tm_we), .waddr_i(tm_wa), .wdata_i(tm_wd), .raddr_i(tm_ra), .rdata_o(tm_rd));
  gtf_ram #(.Depth(QUEUE_DEPTH), .Width(GW)) u_group (
    .clk_i, .we_i(gr_we), .waddr_i(gr_wa), .wdata_i(gr_wd), .raddr_i(ghead_q), .rdata_o(gr_rd));

  logic out_free;
  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OutDataW'({ostatus_q, ovalue_q});

  logic          accept;
  logic          team_ok;
  logic [TeamW-1:0] t_rd;
  logic [NW-1:0] deq_node;
  logic [NW-1:0] tail_next, head_next;
  assign accept = s_axis_tvalid && s_axis_tready;

  // membership entry, elements beyond the table have no team
  assign t_rd    = (int'(elem_q) < ELEMENTS) ? mo_rd : '0;
  assign team_ok = (t_rd != '0) && (int'(t_rd) <= TEAMS);
  assign tail_next = (gtail_q == NW'(QUEUE_DEPTH - 1)) ? '0 : gtail_q + 1'b1;
  assign head_next = (ghead_q == NW'(QUEUE_DEPTH - 1)) ? '0 : ghead_q + 1'b1;
  assign deq_node  = tm_rd[2*NW-1:NW];

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    count_d   = count_q;
    ghead_d   = ghead_q;
    gtail_d   = gtail_q;
    elem_d    = elem_q;
    node_d    = node_q;
    ti_d      = ti_q;
    solo_d    = solo_q;
    tent_d    = tent_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    ovalue_d  = ovalue_q;
    ostatus_d = ostatus_q;

    mo_we = 1'b0; mo_wa = EW'(in_elem); mo_wd = in_team; mo_ra = EW'(in_elem);
    fr_we = 1'b0; fr_wa = '0; fr_wd = '0; fr_ra = count_q[NW-1:0];
    nv_we = 1'b0; nv_wa = node_q; nv_wd = elem_q; nv_ra = node_q;
    nn_we = 1'b0; nn_wa = node_q; nn_wd = '0; nn_ra = node_q;
    tm_we = 1'b0; tm_wa = ti_q; tm_wd = '0; tm_ra = ti_q;
    gr_we = 1'b0; gr_wa = gtail_q; gr_wd = '0;

    unique case (state_q)
      ST_CLR: begin
        mo_we = int'(sweep_q) < ELEMENTS;
        mo_wa = EW'(sweep_q);
        mo_wd = '0;
        fr_we = int'(sweep_q) < QUEUE_DEPTH;
        fr_wa = NW'(sweep_q);
        fr_wd = NW'(sweep_q);
        tm_we = int'(sweep_q) < TEAMS;
        tm_wa = TW'(sweep_q);
        tm_wd = '0;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == SW'(SD - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          elem_d    = in_elem;
          ovalue_d  = '0;
          ostatus_d = STS_DONE;
          unique case (cmd_e'(in_cmd))
            CMD_ASSIGN: begin
              mo_we = (in_team != '0) && (int'(in_team) <= TEAMS)
                      && (int'(in_elem) < ELEMENTS);
              ovalid_d = 1'b1;
            end
            CMD_ENQUEUE: begin
              if (int'(count_q) >= QUEUE_DEPTH) begin
                ostatus_d = STS_FULL;
                ovalid_d  = 1'b1;
              end else begin
                state_d = ST_ENQ1;
              end
            end
            CMD_DEQUEUE: begin
              if (count_q == '0) begin
                ostatus_d = STS_EMPTY;
                ovalid_d  = 1'b1;
              end else begin
                state_d = ST_DEQ1;
              end
            end
            CMD_CLEAR: begin
              ovalid_d = 1'b1;
              sweep_d  = '0;
              count_d  = '0;
              ghead_d  = '0;
              gtail_d  = '0;
              state_d  = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_ENQ1: begin
        // fresh node from the free stack, write its payload now
        node_d = fr_rd;
        nv_we = 1'b1; nv_wa = fr_rd; nv_wd = elem_q;
        nn_we = 1'b1; nn_wa = fr_rd; nn_wd = '0;
        count_d = count_q + 1'b1;
        ti_d  = TW'(t_rd - 1'b1);
        tm_ra = TW'(t_rd - 1'b1);
        if (team_ok) begin
          state_d = ST_ENQ2;
        end else begin
          gr_we = 1'b1;
          gr_wd = {1'b1, (GW-1)'(fr_rd)};
          gtail_d = tail_next;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_ENQ2: begin
        tm_we = 1'b1;
        if (tm_rd[XW-1]) begin
          // team already waiting, link behind its tail
          nn_we = 1'b1; nn_wa = tm_rd[NW-1:0]; nn_wd = node_q;
          tm_wd = {1'b1, tm_rd[2*NW-1:NW], node_q};
        end else begin
          tm_wd = {1'b1, node_q, node_q};
          gr_we = 1'b1;
          gr_wd = {1'b0, (GW-1)'(ti_q)};
          gtail_d = tail_next;
        end
        ovalid_d = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_DEQ1: begin
        solo_d = gr_rd[GW-1];
        node_d = gr_rd[NW-1:0];
        ti_d   = gr_rd[TW-1:0];
        nv_ra  = gr_rd[NW-1:0];
        tm_ra  = gr_rd[TW-1:0];
        state_d = gr_rd[GW-1] ? ST_DEQ3 : ST_DEQ2;
      end
      ST_DEQ2: begin
        tent_d = tm_rd;
        node_d = deq_node;
        nv_ra  = deq_node;
        nn_ra  = deq_node;
        state_d = ST_DEQ3;
      end
      ST_DEQ3: begin
        if (solo_q) begin
          ghead_d = head_next;
        end else if (node_q == tent_q[NW-1:0]) begin
          // last member leaves, team drops out of the order
          tm_we = 1'b1;
          tm_wd = {1'b0, tent_q[2*NW-1:0]};
          ghead_d = head_next;
        end else begin
          tm_we = 1'b1;
          tm_wd = {1'b1, nn_rd, tent_q[NW-1:0]};
        end
        fr_we = 1'b1;
        fr_wa = NW'(count_q - 1'b1);
        fr_wd = node_q;
        count_d   = count_q - 1'b1;
        ovalue_d  = nv_rd;
        ostatus_d = STS_VALUE;
        ovalid_d  = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      sweep_q   <= '0;
      count_q   <= '0;
      ghead_q   <= '0;
      gtail_q   <= '0;
      ovalid_q  <= 1'b0;
      ostatus_q <= '0;
      ovalue_q  <= '0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      count_q   <= count_d;
      ghead_q   <= ghead_d;
      gtail_q   <= gtail_d;
      ovalid_q  <= ovalid_d;
      ostatus_q <= ostatus_d;
      ovalue_q  <= ovalue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    node_q <= node_d;
    ti_q   <= ti_d;
    solo_q <= solo_d;
    tent_q <= tent_d;
  end

endmodule
